/* rtl/core/circular_list_insert_remove_rotate_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the circular list block
// Shared property forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_INSERT_REMOVE_ROTATE_ASSERT_SVH
`define CIRCULAR_LIST_INSERT_REMOVE_ROTATE_ASSERT_SVH

// same-cycle implication, off while in reset
`define CL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular list check failed");

// next-cycle implication, off while in reset
`define CL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular list check failed");

`endif

/* rtl/core/clist_pkg.sv */
// ----------------------------------------------------------------------------
// clist_pkg
// Types, codes and constants shared by the circular list modules.
// ----------------------------------------------------------------------------
package clist_pkg;

    localparam int CL_MAX_ENTRIES_DEF = 16;
    localparam int DATA_W = 32;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_ROTATE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // last step of the 32-step remainder loop
    localparam logic [4:0] DIV_STEP_LAST = 5'd31;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [DATA_W-1:0] operand;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
    } rsp_item_t;

    // store read address source
    typedef enum logic [1:0] {
        RD_LAST = 2'd0,
        RD_IDX  = 2'd1,
        RD_NEXT = 2'd2,
        RD_REM  = 2'd3
    } rd_src_t;

    // store write address/data source
    typedef enum logic {
        WR_TAIL  = 1'b0,
        WR_SHIFT = 1'b1
    } wr_src_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_item;
        logic       wr_en;
        wr_src_t    wr_src;
        logic       rd_en;
        rd_src_t    rd_src;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       idx_clr;
        logic       idx_inc;
        logic       div_init;
        logic       div_step;
        logic       set_status;
        logic [1:0] status_code;
        logic       take_value;
        logic       out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       empty;
        logic       match;
        logic       idx_more;
        logic       div_last;
        logic       out_busy;
    } dp_stat_t;

endpackage

/* rtl/core/circular_list_insert_remove_rotate.sv */
// ----------------------------------------------------------------------------
// circular_list_insert_remove_rotate
// Ordered circular list of signed 32-bit values in a store of MAX_ENTRIES
// slots. One beat in gives exactly one beat out. Insert (cmd 0) appends after
// the newest entry or returns status full. Remove (cmd 1) checks the newest
// entry, then scans from the oldest upward, deletes the first match and
// compacts the entries behind it; otherwise it returns empty or not found.
// Rotate (cmd 2) returns the entry at (steps mod count) from the oldest, with
// negative steps taken as zero. read_value is zero except on a good rotate;
// unused command codes change nothing and return status ok. Items are handled
// one at a time; rotate runs the 32-step bit-serial remainder unit, and remove
// takes longer the more entries it scans and compacts, since the store gives
// one read per cycle and every compaction move is a read followed by a write.
// A finished result sits in an output register, so the next command beat is
// taken while the previous result is still stalled. No clearing pass follows
// reset; the store holds no valid bits.
// ----------------------------------------------------------------------------
module circular_list_insert_remove_rotate
    import clist_pkg::*;
#(
    parameter int MAX_ENTRIES = CL_MAX_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_item
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencer: one command in flight, drives the datapath step by step
    clist_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    // store, counters, remainder unit and result register
    clist_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_item  (rsp_item)
    );

endmodule

/* rtl/core/clist_dp.sv */
// ----------------------------------------------------------------------------
// clist_dp
// Entry store, count, scan index, remainder unit and result register.
// ----------------------------------------------------------------------------
`include "circular_list_insert_remove_rotate_assert.svh"

module clist_dp
    import clist_pkg::*;
#(
    parameter int MAX_ENTRIES = CL_MAX_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_item_t cmd_item,
    input  dp_cmd_t   ctl,
    output dp_stat_t  stat,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output rsp_item_t rsp_item
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [DATA_W-1:0] mem [MAX_ENTRIES];

    logic [CW-1:0]     count_reg;
    logic [IW-1:0]     idx_reg;
    logic [1:0]        cmd_reg;
    logic [DATA_W-1:0] operand_reg;
    logic [DATA_W-1:0] dvd_reg;
    logic [CW-1:0]     rem_reg;
    logic [4:0]        step_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] value_reg;
    logic              rsp_valid_reg;
    rsp_item_t         rsp_item_reg;

    logic [CW-1:0]     idx_plus1;
    logic [CW-1:0]     last_idx;
    logic [CW:0]       trial;
    logic [CW:0]       trial_diff;
    logic              trial_ge;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign idx_plus1  = CW'(idx_reg) + CW'(1);
    assign last_idx   = count_reg - CW'(1);
    assign trial      = {rem_reg, dvd_reg[DATA_W-1]};
    assign trial_diff = trial - {1'b0, count_reg};
    assign trial_ge   = trial >= {1'b0, count_reg};

    always_comb
    begin
        case (ctl.rd_src)
            RD_LAST: rd_addr = last_idx[IW-1:0];
            RD_IDX:  rd_addr = idx_reg;
            RD_NEXT: rd_addr = idx_plus1[IW-1:0];
            RD_REM:  rd_addr = rem_reg[IW-1:0];
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.wr_src)
            WR_TAIL:
            begin
                wr_addr = count_reg[IW-1:0];
                wr_data = operand_reg;
            end
            WR_SHIFT:
            begin
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
            end
            default:
            begin
                wr_addr = idx_reg;
                wr_data = rd_data_reg;
            end
        endcase
    end

    // single-port-style store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            cmd_reg     <= cmd_item.cmd;
            operand_reg <= cmd_item.operand;
            status_reg  <= ST_OK;
            value_reg   <= '0;
        end
        else
        begin
            if (ctl.set_status)
            begin
                status_reg <= ctl.status_code;
            end
            if (ctl.take_value)
            begin
                value_reg <= rd_data_reg;
            end
        end

        // steps mod count, one quotient bit per cycle; negative steps read as zero
        if (ctl.div_init)
        begin
            rem_reg <= '0;
            dvd_reg <= operand_reg[DATA_W-1] ? '0 : operand_reg;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= trial_ge ? trial_diff[CW-1:0] : trial[CW-1:0];
            dvd_reg <= {dvd_reg[DATA_W-2:0], 1'b0};
        end

        if (ctl.out_load)
        begin
            rsp_item_reg.status     <= status_reg;
            rsp_item_reg.read_value <= value_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.cnt_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (ctl.cnt_dec)
            begin
                count_reg <= count_reg - CW'(1);
            end

            if (ctl.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (ctl.idx_inc)
            begin
                idx_reg <= idx_plus1[IW-1:0];
            end

            if (ctl.div_init)
            begin
                step_reg <= '0;
            end
            else if (ctl.div_step)
            begin
                step_reg <= step_reg + 5'd1;
            end

            if (ctl.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.cmd      = cmd_reg;
    assign stat.full     = (count_reg == CW'(MAX_ENTRIES));
    assign stat.empty    = (count_reg == '0);
    assign stat.match    = (rd_data_reg == operand_reg);
    assign stat.idx_more = (idx_plus1 < count_reg);
    assign stat.div_last = (step_reg == DIV_STEP_LAST);
    assign stat.out_busy = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    `CL_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ENTRIES))
    `CL_ASSERT_IMP(a_tail_not_full, clk, rst_n, ctl.wr_en && ctl.wr_src == WR_TAIL, !stat.full)
    `CL_ASSERT_IMP(a_load_free, clk, rst_n, ctl.out_load, !(rsp_valid_reg && rsp_stall))
    `CL_ASSERT_NXT(a_rem_below, clk, rst_n, ctl.div_step, rem_reg < count_reg)

endmodule

/* rtl/core/clist_ctrl.sv */
// ----------------------------------------------------------------------------
// clist_ctrl
// Sequencer for insert, remove (check newest, scan, compact) and rotate.
// ----------------------------------------------------------------------------
module clist_ctrl
    import clist_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DECODE    = 12'b0000_0000_0010,
        S_LAST_CMP  = 12'b0000_0000_0100,
        S_SCAN_RD   = 12'b0000_0000_1000,
        S_SCAN_CMP  = 12'b0000_0001_0000,
        S_SHIFT_RD  = 12'b0000_0010_0000,
        S_SHIFT_WR  = 12'b0000_0100_0000,
        S_DIV       = 12'b0000_1000_0000,
        S_ROT_RD    = 12'b0001_0000_0000,
        S_ROT_DATA  = 12'b0010_0000_0000,
        S_DONE      = 12'b0100_0000_0000,
        S_SPARE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = ST_FULL;
                        end
                        else
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wr_src  = WR_TAIL;
                            ctl.cnt_inc = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    CMD_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_src = RD_LAST;
                            state_next = S_LAST_CMP;
                        end
                    end
                    CMD_ROTATE:
                    begin
                        if (stat.empty)
                        begin
                            ctl.set_status  = 1'b1;
                            ctl.status_code = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ctl.div_init = 1'b1;
                            state_next   = S_DIV;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_LAST_CMP:
            begin
                if (stat.match)
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    ctl.idx_clr = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.idx_more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_src = RD_IDX;
                    state_next = S_SCAN_CMP;
                end
                else
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = ST_NOTFOUND;
                    state_next      = S_DONE;
                end
            end
            S_SCAN_CMP:
            begin
                if (stat.match)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.idx_more)
                begin
                    ctl.rd_en  = 1'b1;
                    ctl.rd_src = RD_NEXT;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SHIFT_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_src  = WR_SHIFT;
                ctl.idx_inc = 1'b1;
                state_next  = S_SHIFT_RD;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_ROT_RD;
                end
            end
            S_ROT_RD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = RD_REM;
                state_next = S_ROT_DATA;
            end
            S_ROT_DATA:
            begin
                ctl.take_value = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

endmodule

/* tb/circular_list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_list_checker
// Watches both channels of the circular list block. It keeps its own copy of
// the list, works out the status and read value of every command beat it
// sees taken, and compares each response beat with the oldest prediction.
// ----------------------------------------------------------------------------
module circular_list_checker
    import clist_pkg::*;
#(
    parameter int MAX_ENTRIES = CL_MAX_ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  cmd_item_t cmd_item,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp_item,
    output int        mismatches,
    output int        pending_rsps
);

    logic [DATA_W-1:0] list_vals [MAX_ENTRIES];
    int                list_len;
    rsp_item_t         predicted_rsps [$];

    initial begin
        mismatches   = 0;
        pending_rsps = 0;
        list_len     = 0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // applies one command to the list copy and gives the response it causes
    task automatic list_apply(input cmd_item_t c, output rsp_item_t r);
        int                hit;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] steps;
        v            = c.operand;
        hit          = -1;
        r.status     = ST_OK;
        r.read_value = '0;
        case (c.cmd)
            CMD_INSERT:
            begin
                if (list_len >= MAX_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    list_vals[list_len] = v;
                    list_len++;
                end
            end
            CMD_REMOVE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    // newest entry first, then oldest upward
                    if (list_vals[list_len-1] == v)
                        hit = list_len - 1;
                    else
                        for (int k = 0; k < list_len - 1; k++)
                            if (hit < 0 && list_vals[k] == v)
                                hit = k;
                    if (hit < 0)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        for (int k = hit; k < list_len - 1; k++)
                            list_vals[k] = list_vals[k+1];
                        list_len--;
                    end
                end
            end
            CMD_ROTATE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    steps        = v[DATA_W-1] ? '0 : v;
                    r.read_value = list_vals[steps % list_len];
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        rsp_item_t want;
        rsp_item_t got;
        if (!rst_n)
        begin
            list_len = 0;
            predicted_rsps.delete();
        end
        else
        begin
            // response first, so a stray beat can never pair with a command
            // taken at the same edge
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_rsps.size() == 0)
                    report_mismatch("response beat with nothing expected");
                else
                begin
                    want = predicted_rsps.pop_front();
                    if (rsp_item.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_item.status, want.status));
                    if (rsp_item.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %h want %h",
                                                  rsp_item.read_value, want.read_value));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                list_apply(cmd_item, got);
                predicted_rsps.push_back(got);
            end
        end
        pending_rsps = predicted_rsps.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the circular list block. A directed pass walks
// the empty, full, not-found and negative-step corners, then a random pass
// swings the list between empty and full with values drawn mostly from a
// small pool so that removes hit. Both channels idle at random; the checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb
    import clist_pkg::*;
;

    localparam int DEPTH       = CL_MAX_ENTRIES_DEF;
    localparam int RANDOM_OPS  = 750;
    localparam int IDLE_LIMIT  = 3000;  // well above the worst item plus the worst gap and the worst stall
    localparam int DRAIN_WAIT  = 100;   // quiet cycles to catch a stray response beat

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    int mismatches;
    int pending_rsps;

    // pool of values shared by inserts and removes, extremes included
    logic [DATA_W-1:0] val_pool [8];

    int gap_mode;
    int idle_cycles;

    // receiver stall pattern state
    int hold_left;
    int calm_left;
    int stall_roll;

    always #5 clk = ~clk;

    circular_list_insert_remove_rotate #(
        .MAX_ENTRIES(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item (cmd_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item (rsp_item)
    );

    circular_list_checker #(
        .MAX_ENTRIES(DEPTH)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_item    (cmd_item),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp_item    (rsp_item),
        .mismatches  (mismatches),
        .pending_rsps(pending_rsps)
    );

    // Response side: short stall bursts, the odd long one, and calm
    // stretches with no stall at all.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left = 0;
            calm_left = 0;
        end
        else if (hold_left > 0)
            hold_left--;
        else if (calm_left > 0)
        begin
            calm_left--;
            rsp_stall <= 1'b0;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3)
            begin
                rsp_stall <= 1'b0;
                calm_left = $urandom_range(50, 200);
            end
            else if (stall_roll < 50)
            begin
                rsp_stall <= 1'b0;
                hold_left = $urandom_range(0, 3);
            end
            else if (stall_roll < 95)
            begin
                rsp_stall <= 1'b1;
                hold_left = $urandom_range(0, 2);
            end
            else
            begin
                rsp_stall <= 1'b1;
                hold_left = $urandom_range(10, 60);
            end
        end
    end

    // Watchdog: too long with no beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Present one command beat and hold it until taken. valid stays high
    // on return so a back-to-back beat never lowers and raises it.
    task automatic send_beat(input logic [1:0] op, input logic [DATA_W-1:0] arg);
        cmd_item_t beat;
        beat.cmd     = op;
        beat.operand = arg;
        cmd_valid <= 1'b1;
        cmd_item  <= beat;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Sender gap after a beat: none in quiet mode, else none or short, with the odd long one.
    task automatic sender_gap();
        int n;
        int roll;
        n    = 0;
        roll = $urandom_range(0, 19);
        if (gap_mode != 0)
        begin
            if (roll >= 18)
                n = $urandom_range(10, 40);
            else if (roll >= 12)
                n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return val_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // rotate steps: mostly a few laps of the list, some full-range and negative
    function automatic logic [DATA_W-1:0] pick_steps();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return $urandom_range(0, 40);
        if (roll < 8)
            return $urandom;
        if (roll < 9)
            return -$urandom_range(1, 5);
        return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endfunction

    initial
    begin
        int ops_done;
        int insert_pct;
        int roll;

        val_pool[0] = 32'h8000_0000;
        val_pool[1] = 32'h7fff_ffff;
        val_pool[2] = 32'h0000_0000;
        val_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++)
            val_pool[i] = $urandom;
        gap_mode = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed corners ----
        // empty list: rotate and remove both report empty
        send_beat(CMD_ROTATE, 32'd5);
        send_beat(CMD_REMOVE, 32'd7);
        // unused code: no effect, ok status
        send_beat(2'd3, 32'hffff_ffff);
        // value extremes
        send_beat(CMD_INSERT, 32'h8000_0000);
        send_beat(CMD_INSERT, 32'h7fff_ffff);
        send_beat(CMD_INSERT, 32'h0000_0000);
        send_beat(CMD_INSERT, 32'hffff_ffff);
        // negative steps read the oldest; largest positive wraps
        send_beat(CMD_ROTATE, 32'hffff_ffff);
        send_beat(CMD_ROTATE, 32'h7fff_ffff);
        send_beat(CMD_ROTATE, 32'h8000_0000);
        // remove hitting the newest, then one found by the scan, then a miss
        send_beat(CMD_REMOVE, 32'hffff_ffff);
        send_beat(CMD_REMOVE, 32'h8000_0000);
        send_beat(CMD_REMOVE, 32'd12345);
        // fill to the brim, then one insert too many
        for (int i = 0; i < DEPTH - 2; i++)
            send_beat(CMD_INSERT, $urandom);
        send_beat(CMD_INSERT, 32'd1);
        send_beat(CMD_ROTATE, DEPTH - 1);

        // ---- random part ----
        // insert bias is re-rolled every 40 ops so the list swings between
        // full and empty; gap mode every 60 ops
        ops_done   = 0;
        insert_pct = 50;
        while (ops_done < RANDOM_OPS)
        begin
            if (ops_done % 40 == 0)
            begin
                roll = $urandom_range(0, 2);
                insert_pct = (roll == 0) ? 80 : (roll == 1) ? 50 : 25;
            end
            if (ops_done % 60 == 0)
                gap_mode = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 3)
                send_beat(2'd3, $urandom);   // ignored, does not count
            else if (roll < insert_pct)
            begin
                send_beat(CMD_INSERT, pick_value());
                ops_done++;
            end
            else if ($urandom_range(0, 9) < 6)
            begin
                send_beat(CMD_REMOVE, pick_value());
                ops_done++;
            end
            else
            begin
                send_beat(CMD_ROTATE, pick_steps());
                ops_done++;
            end
            sender_gap();
        end

        // wait on the clock first so the checker has queued the last beat taken
        cmd_valid <= 1'b0;
        @(posedge clk);
        wait (pending_rsps == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/clist_pkg.sv
rtl/core/clist_dp.sv
rtl/core/clist_ctrl.sv
rtl/core/circular_list_insert_remove_rotate.sv
tb/circular_list_checker.sv
tb/tb.sv
